[rtl/mspk_pkg.sv]
package mspk_pkg;
  localparam int MAX_DEPTH = 16;
  localparam int SP_W = $clog2(MAX_DEPTH + 1);
  localparam int IX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  localparam logic [3:0] K_UINT = 4'd0, K_INT = 4'd1, K_NIL = 4'd2, K_BOOL = 4'd3,
    K_F32 = 4'd4, K_F64 = 4'd5, K_STR = 4'd6, K_BIN = 4'd7, K_ARR = 4'd8,
    K_MAP = 4'd9, K_EXT = 4'd10, K_PAY = 4'd11, K_ERR = 4'd12;

  localparam logic [2:0] E_NONE = 3'd0, E_MARKER = 3'd1, E_TRUNC = 3'd2,
    E_DEEP = 3'd3, E_KEY = 3'd4;

  localparam logic [2:0] PH_MARKER = 3'd0, PH_FIELD = 3'd1, PH_INT_FIRST = 3'd2,
    PH_EXTTYPE = 3'd3, PH_PAYLOAD = 3'd4;

  localparam logic [0:0] CFG_DEPTH = 1'b0, CFG_PASS = 1'b1;

  typedef struct packed {
    logic        is_map;
    logic [32:0] cnt;
  } nest_t;
endpackage

[rtl/msgpack_stream_token_parser_unit.sv]
// MessagePack-style stream token parser.
// Input channel: one encoded byte per beat (in_data_byte) with in_last_byte
// marking the final byte of a buffer; a beat is taken when in_valid is high
// and in_stall low. Result channel: at most one token per input byte, held
// in an output register until out_stall is low.
// A byte that completes no item is registered, then decoded in the decode
// state, which updates the parse state and registers the byte's token. A
// byte that completes an item then walks the nesting stack through the
// shared count decrement/compare unit, one entry a cycle; a final step
// decrements the count of the innermost container still open, if any, and
// registers the token. A stalled result holds the block before the next byte.
// Configuration (cfg_index 0 depth limit, 1 payload pass) is written through
// cfg_valid/cfg_ready at any time the block is idle; cfg_ready is always high.
// Reset: parse state returns to awaiting a marker, depth limit 16, payload
// pass on. The nesting stack needs no clearing. After the top value ends or
// an error, bytes are dropped until the last byte, then the parser restarts.
module msgpack_stream_token_parser_unit import mspk_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_data_byte,
  input  logic              in_last_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [3:0]        out_kind,
  output logic [63:0]       out_value,
  output logic signed [7:0] out_ext_kind,
  output logic [4:0]        out_nest_level,
  output logic [2:0]        out_error_code,
  output logic              out_top_done,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [0:0]        cfg_index,
  input  logic [4:0]        cfg_data
);
  localparam logic [1:0] S_IDLE = 2'd0, S_DEC = 2'd1, S_POP = 2'd2;

  logic [1:0]  st_r;
  logic [4:0]  lim_r;
  logic        pass_r;
  logic [7:0]  b_r;
  logic        last_r;
  logic [2:0]  ph_r;
  logic [3:0]  fbl_r;
  logic [63:0] aw_r;
  logic [3:0]  pk_r;
  logic [31:0] pl_r;
  logic [SP_W-1:0] sp_r;
  logic        fin_r;
  logic        emit_r;   // token pending while popping
  logic        lastp_r;  // popping for the last byte of the buffer
  nest_t       stk_r [MAX_DEPTH];
  nest_t       top_e;

  logic [SP_W-1:0] eff_lim;
  always_comb begin
    if (lim_r == 5'd0) eff_lim = SP_W'(1);
    else if (32'(lim_r) > MAX_DEPTH) eff_lim = SP_W'(MAX_DEPTH);
    else eff_lim = SP_W'(lim_r);
  end

  assign cfg_ready = 1'b1;
  assign in_stall = (st_r != S_IDLE) || (out_valid && out_stall);
  assign top_e = stk_r[IX_W'(sp_r - SP_W'(1))];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= 5'd16;
      pass_r <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DEPTH: lim_r <= cfg_data;
        CFG_PASS:  pass_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // decode step outputs
  logic        d_emit, d_done, d_fail, d_push;
  logic [3:0]  d_kind;
  logic [63:0] d_val;
  logic [7:0]  d_ext;
  logic [2:0]  d_err, d_ph;
  logic [3:0]  d_fbl, d_pk;
  logic [63:0] d_aw;
  logic [31:0] d_pl;
  nest_t       d_ent;
  logic        is_str;
  logic [63:0] hlen;
  logic [3:0]  hkind;
  logic        hdr;
  logic [63:0] nw;
  logic [3:0]  nf;
  logic        trunc_now;

  always_comb begin
    d_emit = 1'b0; d_done = 1'b0; d_fail = 1'b0; d_push = 1'b0;
    d_kind = K_UINT; d_val = '0; d_ext = '0; d_err = E_NONE;
    d_ph = PH_MARKER; d_fbl = fbl_r; d_pk = pk_r; d_aw = aw_r; d_pl = pl_r;
    d_ent = '0; hdr = 1'b0; hlen = '0; hkind = K_STR;
    is_str = (b_r[7:5] == 3'b101) || (b_r >= 8'hd9 && b_r <= 8'hdb);
    nw = '0; nf = '0;
    case (ph_r)
      PH_FIELD, PH_INT_FIRST: begin
        if (ph_r == PH_INT_FIRST) nw = {{56{b_r[7]}}, b_r};
        else nw = {aw_r[55:0], b_r};
        nf = (fbl_r != 4'd0) ? fbl_r - 4'd1 : 4'd0;
        d_aw = nw; d_fbl = nf; d_ph = PH_FIELD;
        if (nf == 4'd0) begin
          d_ph = PH_MARKER;
          if (pk_r <= K_F64) begin
            d_emit = 1'b1; d_kind = pk_r; d_val = nw; d_done = 1'b1;
          end else begin
            hdr = 1'b1; hkind = pk_r; hlen = nw;
          end
        end
      end
      PH_EXTTYPE: begin
        d_emit = 1'b1; d_kind = K_EXT; d_val = {32'd0, pl_r}; d_ext = b_r;
        if (pl_r == 32'd0) d_done = 1'b1;
        else d_ph = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        d_pl = (pl_r != 32'd0) ? pl_r - 32'd1 : 32'd0;
        d_emit = pass_r; d_kind = K_PAY; d_val = {56'd0, b_r};
        if (d_pl == 32'd0) d_done = 1'b1;
        else d_ph = PH_PAYLOAD;
      end
      default: begin
        if (sp_r != '0 && top_e.is_map && !top_e.cnt[0] && !is_str) begin
          d_fail = 1'b1; d_err = E_KEY;
        end else if (b_r <= 8'h7f) begin
          d_emit = 1'b1; d_kind = K_UINT; d_val = {56'd0, b_r}; d_done = 1'b1;
        end else if (b_r >= 8'he0) begin
          d_emit = 1'b1; d_kind = K_INT; d_val = {{56{1'b1}}, b_r}; d_done = 1'b1;
        end else if (b_r <= 8'h8f) begin
          hdr = 1'b1; hkind = K_MAP; hlen = {60'd0, b_r[3:0]};
        end else if (b_r <= 8'h9f) begin
          hdr = 1'b1; hkind = K_ARR; hlen = {60'd0, b_r[3:0]};
        end else if (b_r <= 8'hbf) begin
          hdr = 1'b1; hkind = K_STR; hlen = {59'd0, b_r[4:0]};
        end else begin
          case (b_r)
            8'hc0: begin d_emit = 1'b1; d_kind = K_NIL; d_done = 1'b1; end
            8'hc2, 8'hc3: begin
              d_emit = 1'b1; d_kind = K_BOOL; d_val = {63'd0, b_r[0]}; d_done = 1'b1;
            end
            8'hc4, 8'hc5, 8'hc6: begin
              d_pk = K_BIN; d_fbl = 4'd1 << b_r[1:0]; d_aw = '0; d_ph = PH_FIELD;
            end
            8'hc7, 8'hc8, 8'hc9: begin
              d_pk = K_EXT; d_fbl = 4'd1 << (b_r[1:0] - 2'd3); d_aw = '0; d_ph = PH_FIELD;
            end
            8'hca: begin d_pk = K_F32; d_fbl = 4'd4; d_aw = '0; d_ph = PH_FIELD; end
            8'hcb: begin d_pk = K_F64; d_fbl = 4'd8; d_aw = '0; d_ph = PH_FIELD; end
            8'hcc, 8'hcd, 8'hce, 8'hcf: begin
              d_pk = K_UINT; d_fbl = 4'd1 << b_r[1:0]; d_aw = '0; d_ph = PH_FIELD;
            end
            8'hd0, 8'hd1, 8'hd2, 8'hd3: begin
              d_pk = K_INT; d_fbl = 4'd1 << b_r[1:0]; d_aw = '0; d_ph = PH_INT_FIRST;
            end
            8'hd4, 8'hd5, 8'hd6, 8'hd7, 8'hd8: begin
              hdr = 1'b1; hkind = K_EXT;
              hlen = 64'd1 << (b_r[3:0] - 4'h4);
            end
            8'hd9, 8'hda, 8'hdb: begin
              d_pk = K_STR; d_fbl = 4'd1 << (b_r[1:0] - 2'd1); d_aw = '0; d_ph = PH_FIELD;
            end
            8'hdc, 8'hdd: begin
              d_pk = K_ARR; d_fbl = 4'd2 << b_r[0]; d_aw = '0; d_ph = PH_FIELD;
            end
            8'hde, 8'hdf: begin
              d_pk = K_MAP; d_fbl = 4'd2 << b_r[0]; d_aw = '0; d_ph = PH_FIELD;
            end
            default: begin d_fail = 1'b1; d_err = E_MARKER; end
          endcase
        end
      end
    endcase
    if (hdr) begin
      d_ph = PH_MARKER;
      if (hkind == K_EXT) begin
        if (hlen == '0) begin d_fail = 1'b1; d_err = E_TRUNC; end
        else begin d_pl = 32'(hlen - 64'd1); d_ph = PH_EXTTYPE; end
      end else if (hkind == K_STR || hkind == K_BIN) begin
        d_emit = 1'b1; d_kind = hkind; d_val = hlen;
        if (hlen == '0) d_done = 1'b1;
        else begin d_pl = hlen[31:0]; d_ph = PH_PAYLOAD; end
      end else if (hlen == '0) begin
        d_emit = 1'b1; d_kind = hkind; d_done = 1'b1;
      end else if (sp_r >= eff_lim) begin
        d_fail = 1'b1; d_err = E_DEEP;
      end else begin
        d_emit = 1'b1; d_kind = hkind; d_val = hlen; d_push = 1'b1;
        d_ent.is_map = (hkind == K_MAP);
        d_ent.cnt = (hkind == K_MAP) ? {hlen[31:0], 1'b0} : hlen[32:0];
      end
    end
    if (d_fail) begin
      d_emit = 1'b1; d_kind = K_ERR; d_val = '0; d_ext = '0; d_done = 1'b0;
      d_push = 1'b0; d_ph = PH_MARKER;
    end
  end

  // last byte leaves the value open without completing an item: truncation
  assign trunc_now = last_r && !fin_r && !d_fail && !d_done;

  always_ff @(posedge clk) begin
    if (d_push && st_r == S_DEC && !fin_r && !last_r) stk_r[IX_W'(sp_r)] <= d_ent;
    else if (st_r == S_POP && sp_r != '0 && top_e.cnt > 33'd1)
      stk_r[IX_W'(sp_r - SP_W'(1))] <= '{is_map: top_e.is_map, cnt: top_e.cnt - 33'd1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; out_valid <= 1'b0; ph_r <= PH_MARKER; fbl_r <= '0;
      pk_r <= '0; pl_r <= '0; sp_r <= '0; fin_r <= 1'b0; emit_r <= 1'b0;
      lastp_r <= 1'b0; aw_r <= '0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (out_valid && !out_stall) out_valid <= 1'b0;
          if (in_valid && !in_stall) begin
            b_r <= in_data_byte; last_r <= in_last_byte; st_r <= S_DEC;
          end
        end
        S_DEC: begin
          if (!fin_r) begin
            out_kind <= trunc_now ? K_ERR : d_kind;
            out_value <= trunc_now ? 64'd0 : d_val;
            out_ext_kind <= trunc_now ? 8'sd0 : d_ext;
            out_nest_level <= trunc_now ? 5'(sp_r + SP_W'(d_push)) : 5'(sp_r);
            out_error_code <= trunc_now ? E_TRUNC : d_err;
            out_top_done <= 1'b0;
          end
          if (last_r && (fin_r || d_fail || !d_done)) begin
            // end of buffer: emit unless already finished, and restart
            out_valid <= !fin_r; st_r <= S_IDLE;
            ph_r <= PH_MARKER; fbl_r <= '0; pk_r <= '0; aw_r <= '0; pl_r <= '0;
            sp_r <= '0; fin_r <= 1'b0;
          end else if (fin_r) begin
            st_r <= S_IDLE;
          end else begin
            ph_r <= d_ph; fbl_r <= d_fbl; pk_r <= d_pk; aw_r <= d_aw; pl_r <= d_pl;
            if (d_fail) fin_r <= 1'b1;
            if (d_push) sp_r <= sp_r + SP_W'(1);
            if (d_done) begin
              emit_r <= d_emit; lastp_r <= last_r; st_r <= S_POP;
            end else begin
              out_valid <= d_emit; st_r <= S_IDLE;
            end
          end
        end
        S_POP: begin
          if (sp_r == '0 || top_e.cnt > 33'd1) begin
            st_r <= S_IDLE;
            if (lastp_r && sp_r != '0) begin
              out_kind <= K_ERR; out_value <= '0; out_ext_kind <= '0;
              out_nest_level <= 5'(sp_r); out_error_code <= E_TRUNC;
              out_top_done <= 1'b0; out_valid <= 1'b1;
            end else begin
              out_top_done <= (sp_r == '0); out_valid <= emit_r;
            end
            if (lastp_r) begin
              ph_r <= PH_MARKER; fbl_r <= '0; pk_r <= '0; aw_r <= '0; pl_r <= '0;
              sp_r <= '0; fin_r <= 1'b0;
            end else if (sp_r == '0) fin_r <= 1'b1;
          end else sp_r <= sp_r - SP_W'(1);
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/mspk_checker.sv]
module mspk_checker import mspk_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] out_kind,
  input logic [2:0] out_error_code,
  input logic       out_top_done
);
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_kind == K_ERR) == (out_error_code != E_NONE)))
    else $error("error code mismatch");
  a_err_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == K_ERR |-> !out_top_done)
    else $error("top_done on error");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("byte taken while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind))
    else $error("stalled token changed");
endmodule

bind msgpack_stream_token_parser_unit mspk_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
  .out_error_code(out_error_code), .out_top_done(out_top_done)
);
